@@ rtl/assert_macros.svh @@
// Assertion macros shared by the duplicate-suppress RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mdsf_pkg.sv @@
// Types, constants and helpers for the mesh duplicate-suppress forward core.
// No dependencies; used by every module of the block.
package mdsf_pkg;

    localparam int ADDR_W   = 8;
    localparam int TTL_W    = 8;
    localparam int SEQ_W    = 8;
    localparam int TIME_W   = 32;
    localparam int KEY_W    = ADDR_W + SEQ_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS = 1'b1;

    localparam logic [ADDR_W-1:0] NODE_ID_RST   = 8'd20;
    localparam logic [TIME_W-1:0] WINDOW_MS_RST = 32'd30000;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [TTL_W-1:0]  hop_ttl;
        logic [SEQ_W-1:0]  seq_low;
        logic [TIME_W-1:0] now_ms;
    } in_t;

    typedef struct packed {
        logic             duplicate;
        logic             forward;
        logic [TTL_W-1:0] ttl_out;
    } out_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic   en;
        entry_t entry;
    } ring_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    function automatic logic [KEY_W-1:0] make_key(input logic [ADDR_W-1:0] src,
                                                  input logic [SEQ_W-1:0] seq);
        make_key = {src, {SEQ_W{1'b0}}} ^ {{ADDR_W{1'b0}}, seq};
    endfunction

endpackage

@@ rtl/mesh_duplicate_suppress_forward_core.sv @@
// Mesh duplicate suppression and flood-forward decision, top level.
// Depends on mdsf_pkg, mdsf_ctrl, mdsf_match and mdsf_ring.
//
// Each accepted header is checked against a ring of ENTRIES remembered
// (source, sequence) keys with their arrival times; a valid entry with the
// same key younger than window_ms marks it duplicate, otherwise it is stored
// at the ring pointer. One transfer in gives one transfer out with duplicate,
// forward and ttl_out. After accept the ring memory is read one entry per
// cycle through one shared key/age compare unit; the last compare closes the
// scan, the done state inserts and loads the result register, and the idle
// state raises s_ready again, so no new header is taken during a scan. A
// finished result may wait in its register while the next header is scanned;
// if it is still waiting when that scan ends, the block holds until it is
// taken. Entries never written are masked by the ring fill count, so no
// clearing pass follows reset. Configuration writes are registered and
// belong in idle periods.
module mesh_duplicate_suppress_forward_core #(
    parameter int ENTRIES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mdsf_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mdsf_pkg::out_t                      m_data,
    input  logic                                cfg_wr_en,
    input  logic [mdsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mdsf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(ENTRIES);

    logic [mdsf_pkg::ADDR_W-1:0] node_id_reg, node_id_next;
    logic [mdsf_pkg::TIME_W-1:0] window_ms_reg, window_ms_next;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    mdsf_pkg::entry_t   rd_entry;
    logic               rd_live;
    mdsf_pkg::ring_wr_t wr;

    always_comb begin
        node_id_next   = node_id_reg;
        window_ms_next = window_ms_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                mdsf_pkg::CFG_NODE_ID:   node_id_next   = cfg_wdata[mdsf_pkg::ADDR_W-1:0];
                mdsf_pkg::CFG_WINDOW_MS: window_ms_next = cfg_wdata[mdsf_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg   <= mdsf_pkg::NODE_ID_RST;
            window_ms_reg <= mdsf_pkg::WINDOW_MS_RST;
        end else begin
            node_id_reg   <= node_id_next;
            window_ms_reg <= window_ms_next;
        end
    end

    mdsf_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .node_id   (node_id_reg),
        .window_ms (window_ms_reg),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_entry  (rd_entry),
        .rd_live   (rd_live),
        .wr        (wr)
    );

    mdsf_ring #(
        .ENTRIES (ENTRIES)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_live  (rd_live)
    );

endmodule

@@ rtl/mdsf_ring.sv @@
// Ring of remembered keys and time stamps with a wrapping write pointer.
// Depends on mdsf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mdsf_ring #(
    parameter int ENTRIES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mdsf_pkg::ring_wr_t            wr,
    input  logic                          rd_en,
    input  logic [$clog2(ENTRIES)-1:0]    rd_addr,
    output mdsf_pkg::entry_t              rd_entry,
    output logic                          rd_live
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    mdsf_pkg::entry_t mem [ENTRIES];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic          wrapped_reg, wrapped_next;
    mdsf_pkg::entry_t rd_entry_reg;
    logic          rd_live_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_ptr_reg] <= wr.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
            rd_live_reg  <= wrapped_reg || (rd_addr < wr_ptr_reg);
        end
    end

    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        wrapped_next = wrapped_reg;
        if (wr.en) begin
            if (wr_ptr_reg == LAST) begin
                wr_ptr_next  = '0;
                wrapped_next = 1'b1;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            wrapped_reg <= 1'b0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            wrapped_reg <= wrapped_next;
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_live  = rd_live_reg;

    `ASSERT_AT(a_wrapped_sticky, aclk, aresetn, (aresetn && wrapped_reg) |=> wrapped_reg, "ring fill flag cleared")
    `ASSERT_AT(a_ptr_advance, aclk, aresetn, (aresetn && wr.en) |=> ((wr_ptr_reg == $past(wr_ptr_reg) + 1'b1) || (wr_ptr_reg == '0 && $past(wr_ptr_reg) == LAST)), "write pointer did not advance")

endmodule

@@ rtl/mdsf_match.sv @@
// Shared match unit: key compare and wrapping age check for one ring entry.
// Depends on mdsf_pkg.
module mdsf_match (
    input  logic                            check,
    input  mdsf_pkg::entry_t                entry,
    input  logic                            live,
    input  logic [mdsf_pkg::KEY_W-1:0]      key,
    input  logic [mdsf_pkg::TIME_W-1:0]     now_ms,
    input  logic [mdsf_pkg::TIME_W-1:0]     window_ms,
    output logic                            hit
);

    logic [mdsf_pkg::TIME_W-1:0] age;

    assign age = now_ms - entry.stamp;
    assign hit = check && live && (entry.key == key) && (age < window_ms);

endmodule

@@ rtl/mdsf_ctrl.sv @@
// Sequencer: takes a header, scans the ring through the match unit, then
// inserts on a miss and loads the result register. Depends on mdsf_pkg,
// mdsf_match and assert_macros.svh.
`include "assert_macros.svh"
module mdsf_ctrl #(
    parameter int ENTRIES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  mdsf_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output mdsf_pkg::out_t                   m_data,
    input  logic [mdsf_pkg::ADDR_W-1:0]      node_id,
    input  logic [mdsf_pkg::TIME_W-1:0]      window_ms,
    output logic                             rd_en,
    output logic [$clog2(ENTRIES)-1:0]       rd_addr,
    input  mdsf_pkg::entry_t                 rd_entry,
    input  logic                             rd_live,
    output mdsf_pkg::ring_wr_t               wr
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW:0] COUNT = (AW + 1)'(ENTRIES);

    mdsf_pkg::state_t state_reg, state_next;
    mdsf_pkg::in_t    item_reg, item_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             dup_reg, dup_next;
    logic             m_valid_reg, m_valid_next;
    mdsf_pkg::out_t   m_data_reg, m_data_next;

    logic                       accept;
    logic                       out_load;
    logic                       hit;
    logic [mdsf_pkg::KEY_W-1:0] key;

    assign key = mdsf_pkg::make_key(item_reg.src_addr, item_reg.seq_low);

    mdsf_match u_match (
        .check     (cmp_vld_reg),
        .entry     (rd_entry),
        .live      (rd_live),
        .key       (key),
        .now_ms    (item_reg.now_ms),
        .window_ms (window_ms),
        .hit       (hit)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mdsf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = mdsf_pkg::ST_SCAN;
                end
            end
            mdsf_pkg::ST_SCAN: begin
                if (!rd_en && !cmp_vld_reg) begin
                    state_next = mdsf_pkg::ST_DONE;
                end
            end
            mdsf_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = mdsf_pkg::ST_IDLE;
                end
            end
            default: state_next = mdsf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == mdsf_pkg::ST_IDLE);
        accept       = s_ready && s_valid;
        rd_en        = (state_reg == mdsf_pkg::ST_SCAN) && (cnt_reg < COUNT);
        rd_addr      = cnt_reg[AW-1:0];
        out_load     = (state_reg == mdsf_pkg::ST_DONE) && (!m_valid_reg || m_ready);
        item_next    = item_reg;
        cnt_next     = cnt_reg;
        cmp_vld_next = rd_en;
        dup_next     = dup_reg | hit;
        if (accept) begin
            item_next = s_data;
            cnt_next  = '0;
            dup_next  = 1'b0;
        end else if (rd_en) begin
            cnt_next = cnt_reg + 1'b1;
        end
        wr.en          = out_load && !dup_reg;
        wr.entry.key   = key;
        wr.entry.stamp = item_reg.now_ms;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next          = 1'b1;
            m_data_next.duplicate = dup_reg;
            m_data_next.forward   = !dup_reg && (item_reg.dst_addr != node_id)
                                    && (item_reg.hop_ttl != '0);
            m_data_next.ttl_out   = item_reg.hop_ttl - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mdsf_pkg::ST_IDLE;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        cnt_reg    <= cnt_next;
        dup_reg    <= dup_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_AT(a_scan_exit, aclk, aresetn, (aresetn && state_reg == mdsf_pkg::ST_SCAN) |=> (state_reg == mdsf_pkg::ST_SCAN || state_reg == mdsf_pkg::ST_DONE), "scan left to wrong state")
    `ASSERT_AT(a_insert_on_miss, aclk, aresetn, wr.en |-> (state_reg == mdsf_pkg::ST_DONE && !dup_reg), "ring written outside a miss")
    `ASSERT_AT(a_result_load, aclk, aresetn, (aresetn && out_load) |=> (m_valid && m_data.duplicate == $past(dup_reg)), "result not loaded")

endmodule
